// ----- rtl/pth_comp_pkg.sv -----
// Shared types, constants and shift helpers for the sensor compensation pipeline.
// No dependencies.
package pth_comp_pkg;

  localparam int WORD_W = 64;
  typedef logic [WORD_W-1:0] word_t;

  // Configuration register indexes
  localparam logic [2:0] CFG_TEMP       = 3'd0;
  localparam logic [2:0] CFG_PRESS_LOW  = 3'd1;
  localparam logic [2:0] CFG_PRESS_HIGH = 3'd2;
  localparam logic [2:0] CFG_MIXED      = 3'd3;
  localparam logic [2:0] CFG_HUM        = 3'd4;

  localparam word_t       PW_OFFSET  = 64'd128000;
  localparam word_t       PRESS_MUL  = 64'd3125;
  localparam word_t       PRESS_BASE = 64'd1048576;
  localparam logic [31:0] HX_OFFSET  = 32'd76800;
  localparam logic [31:0] HUM_LIMIT  = 32'd419430400;
  localparam logic [31:0] HUM_BIAS   = 32'd2097152;

  function automatic word_t asr64(input word_t x, input int unsigned n);
    logic signed [63:0] s;
    s = x;
    return word_t'(s >>> n);
  endfunction

  function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned n);
    logic signed [31:0] s;
    s = x;
    return 32'(s >>> n);
  endfunction

endpackage

// ----- rtl/pth_comp_delay.sv -----
// Fixed-length delay line for data that rides alongside the pipeline.
// No dependencies.
module pth_comp_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] taps [DEPTH];

  always_ff @(posedge clk) begin
    taps[0] <= din;
    for (int i = 1; i < DEPTH; i++) begin
      taps[i] <= taps[i-1];
    end
  end

  assign dout = taps[DEPTH-1];

endmodule

// ----- rtl/pth_comp_mul64.sv -----
// 64x64 multiply modulo 2^64 from 32-bit partial products, two stages.
// Depends on pth_comp_pkg.
module pth_comp_mul64
  import pth_comp_pkg::*;
(
  input  logic  clk,
  input  word_t a,
  input  word_t b,
  output word_t y
);

  logic [63:0] ll;
  logic [31:0] lh;
  logic [31:0] hl;

  always_ff @(posedge clk) begin
    ll <= {32'd0, a[31:0]} * {32'd0, b[31:0]};
    lh <= a[31:0] * b[63:32];
    hl <= a[63:32] * b[31:0];
    y  <= ll + {lh + hl, 32'd0};
  end

endmodule

// ----- rtl/pth_comp_div64.sv -----
// Pipelined unsigned 64-bit restoring divider, one quotient bit per stage.
// Depends on pth_comp_pkg.
module pth_comp_div64
  import pth_comp_pkg::*;
(
  input  logic  clk,
  input  word_t dividend,
  input  word_t divisor,
  output word_t quotient
);

  word_t rem [WORD_W];
  word_t dq  [WORD_W];
  word_t dvs [WORD_W];

  for (genvar i = 0; i < WORD_W; i++) begin : g_step
    logic [WORD_W:0] trial;
    word_t           rem_in;
    word_t           dq_in;
    word_t           dvs_in;
    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign dq_in  = dividend;
      assign dvs_in = divisor;
    end else begin : g_next
      assign rem_in = rem[i-1];
      assign dq_in  = dq[i-1];
      assign dvs_in = dvs[i-1];
    end
    assign trial = {rem_in, dq_in[WORD_W-1]};
    always_ff @(posedge clk) begin
      dvs[i] <= dvs_in;
      if (trial >= {1'b0, dvs_in}) begin
        rem[i] <= word_t'(trial - {1'b0, dvs_in});
        dq[i]  <= {dq_in[WORD_W-2:0], 1'b1};
      end else begin
        rem[i] <= trial[WORD_W-1:0];
        dq[i]  <= {dq_in[WORD_W-2:0], 1'b0};
      end
    end
  end

  assign quotient = dq[WORD_W-1];

endmodule

// ----- rtl/pth_sensor_compensation_top.sv -----
// Top level: temperature / pressure / humidity compensation pipeline.
// Depends on pth_comp_pkg, pth_comp_mul64, pth_comp_div64, pth_comp_delay.
//
//  port group     dir  handshake        payload
//  measurement    in   start / busy     adc_temp, adc_press, adc_hum
//  result         out  done (1 cycle)   temp_centideg, fine_temp, press_q24_8,
//                                       hum_q22_10, calib_error
//  calibration    in   cfg_we           cfg_addr, cfg_data
//
// One word enters per cycle while busy is low.
// The pipeline depth is set by the 64-stage pressure divider plus the 64-bit
// multiply chain ahead of and behind it.
// busy is high only in the cycle that follows a reset cycle.
// rst clears the calibration registers and all in-flight valids.
// The result side has no back pressure; done pulses once per word.
module pth_sensor_compensation_top
  import pth_comp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [19:0]        adc_temp,
  input  logic [19:0]        adc_press,
  input  logic [15:0]        adc_hum,
  output logic               done,
  output logic signed [31:0] temp_centideg,
  output logic signed [31:0] fine_temp,
  output logic [31:0]        press_q24_8,
  output logic [16:0]        hum_q22_10,
  output logic               calib_error,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_addr,
  input  logic [63:0]        cfg_data
);

  localparam int LAT = 84;

  // ---------------- calibration registers ----------------
  logic [47:0] cal_temp_words;
  logic [63:0] cal_press_low;
  logic [63:0] cal_press_high;
  logic [47:0] cal_mixed_words;
  logic [31:0] cal_hum_words;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_temp_words  <= '0;
      cal_press_low   <= '0;
      cal_press_high  <= '0;
      cal_mixed_words <= '0;
      cal_hum_words   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_TEMP:       cal_temp_words  <= cfg_data[47:0];
        CFG_PRESS_LOW:  cal_press_low   <= cfg_data;
        CFG_PRESS_HIGH: cal_press_high  <= cfg_data;
        CFG_MIXED:      cal_mixed_words <= cfg_data[47:0];
        CFG_HUM:        cal_hum_words   <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Calibration fields, sign/zero extended to the arithmetic width
  function automatic word_t sx16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  logic [31:0] t1, t2, t3, h1, h2, h3, h4, h5, h6;
  word_t       p1, p2, p3, p4, p5, p6, p7, p8, p9;

  assign t1 = {16'd0, cal_temp_words[15:0]};
  assign t2 = {{16{cal_temp_words[31]}}, cal_temp_words[31:16]};
  assign t3 = {{16{cal_temp_words[47]}}, cal_temp_words[47:32]};
  assign p1 = {48'd0, cal_press_low[15:0]};
  assign p2 = sx16(cal_press_low[31:16]);
  assign p3 = sx16(cal_press_low[47:32]);
  assign p4 = sx16(cal_press_low[63:48]);
  assign p5 = sx16(cal_press_high[15:0]);
  assign p6 = sx16(cal_press_high[31:16]);
  assign p7 = sx16(cal_press_high[47:32]);
  assign p8 = sx16(cal_press_high[63:48]);
  assign p9 = sx16(cal_mixed_words[15:0]);
  assign h1 = {24'd0, cal_mixed_words[23:16]};
  assign h2 = {{16{cal_mixed_words[39]}}, cal_mixed_words[39:24]};
  assign h3 = {24'd0, cal_mixed_words[47:40]};
  assign h4 = {{20{cal_hum_words[11]}}, cal_hum_words[11:0]};
  assign h5 = {{20{cal_hum_words[23]}}, cal_hum_words[23:12]};
  assign h6 = {{24{cal_hum_words[31]}}, cal_hum_words[31:24]};

  // ---------------- handshake and valid chain ----------------
  logic           accept;
  logic [LAT-1:0] vld;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      vld  <= '0;
    end else begin
      busy <= 1'b0;
      vld  <= {vld[LAT-2:0], accept};
    end
  end

  assign done = vld[LAT-1];

  // ---------------- temperature, stages 1..4 ----------------
  logic [31:0] at_w, d_w;
  logic [31:0] s1_v1a, s1_dd, s2_v1, s2_m, s3_tf, s4_temp, s4_x;
  word_t       s4_pw;

  assign at_w = {12'd0, adc_temp};
  assign d_w  = (at_w >> 4) - t1;

  always_ff @(posedge clk) begin
    s1_v1a  <= ((at_w >> 3) - (t1 << 1)) * t2;
    s1_dd   <= d_w * d_w;
    s2_v1   <= asr32(s1_v1a, 11);
    s2_m    <= asr32(s1_dd, 12) * t3;
    s3_tf   <= s2_v1 + asr32(s2_m, 14);
    s4_temp <= asr32(s3_tf * 32'd5 + 32'd128, 8);
    s4_pw   <= {{32{s3_tf[31]}}, s3_tf} - PW_OFFSET;
    s4_x    <= s3_tf - HX_OFFSET;
  end

  // ---------------- pressure divisor / dividend ----------------
  word_t sq, a5, a2, b6, b3, s7_a5, s7_a2, s8_a5, s8_a2;
  word_t s9_w2, s9_u, s10_nb, dprod, nprod, s12_d;
  logic [19:0] ap9;

  pth_comp_mul64 u_sq (.clk(clk), .a(s4_pw), .b(s4_pw), .y(sq));
  pth_comp_mul64 u_a5 (.clk(clk), .a(s4_pw), .b(p5),    .y(a5));
  pth_comp_mul64 u_a2 (.clk(clk), .a(s4_pw), .b(p2),    .y(a2));
  pth_comp_mul64 u_b6 (.clk(clk), .a(sq),    .b(p6),    .y(b6));
  pth_comp_mul64 u_b3 (.clk(clk), .a(sq),    .b(p3),    .y(b3));

  pth_comp_delay #(.WIDTH(20), .DEPTH(9)) u_ap_dly (.clk(clk), .din(adc_press), .dout(ap9));

  always_ff @(posedge clk) begin
    s7_a5  <= a5;
    s7_a2  <= a2;
    s8_a5  <= s7_a5;
    s8_a2  <= s7_a2;
    s9_w2  <= b6 + (s8_a5 << 17) + (p4 << 35);
    s9_u   <= asr64(b3, 8) + (s8_a2 << 12) + (64'd1 << 47);
    s10_nb <= ((PRESS_BASE - {44'd0, ap9}) << 31) - s9_w2;
    s12_d  <= asr64(dprod, 33);
  end

  pth_comp_mul64 u_dv (.clk(clk), .a(s9_u),   .b(p1),        .y(dprod));
  pth_comp_mul64 u_nm (.clk(clk), .a(s10_nb), .b(PRESS_MUL), .y(nprod));

  // ---------------- signed divide ----------------
  word_t s13_an, s13_ad, quo, s78_p, s79_p, s80_p, s81_p, s82_p;
  logic  s13_neg, s13_err, neg77, err83;

  always_ff @(posedge clk) begin
    s13_an  <= nprod[63] ? word_t'(64'd0 - nprod) : nprod;
    s13_ad  <= s12_d[63] ? word_t'(64'd0 - s12_d) : s12_d;
    s13_neg <= nprod[63] ^ s12_d[63];
    s13_err <= (s12_d == '0);
  end

  pth_comp_div64 u_div (.clk(clk), .dividend(s13_an), .divisor(s13_ad), .quotient(quo));

  pth_comp_delay #(.WIDTH(1), .DEPTH(64)) u_neg_dly (.clk(clk), .din(s13_neg), .dout(neg77));
  pth_comp_delay #(.WIDTH(1), .DEPTH(70)) u_err_dly (.clk(clk), .din(s13_err), .dout(err83));

  // ---------------- pressure correction ----------------
  word_t qq, pp8, m9, s81_pp8, s82_pp8, s83_sum, r_w;

  pth_comp_mul64 u_qq (.clk(clk), .a(asr64(s78_p, 13)), .b(asr64(s78_p, 13)), .y(qq));
  pth_comp_mul64 u_p8 (.clk(clk), .a(s78_p), .b(p8), .y(pp8));
  pth_comp_mul64 u_m9 (.clk(clk), .a(qq),    .b(p9), .y(m9));

  always_ff @(posedge clk) begin
    s78_p   <= neg77 ? word_t'(64'd0 - quo) : quo;
    s79_p   <= s78_p;
    s80_p   <= s79_p;
    s81_p   <= s80_p;
    s82_p   <= s81_p;
    s81_pp8 <= pp8;
    s82_pp8 <= s81_pp8;
    s83_sum <= s82_p + asr64(m9, 25) + asr64(s82_pp8, 19);
  end

  assign r_w = asr64(s83_sum, 8) + (p7 << 4);

  // ---------------- humidity, stages 5..14 ----------------
  logic [15:0] ah5;
  logic [31:0] s5_h5x, s5_x6, s5_x3, s6_a, s6_f1, s6_f2, s7_bm, s7_a;
  logic [31:0] s8_b1, s8_a, s9_b2, s9_a, s10_b, s10_a, s11_xx;
  logic [31:0] s12_ss, s12_xx, s13_t, s13_xx, hx_w, s14_s_w;
  logic [16:0] s14_hum, hum83;
  logic [31:0] tf83, temp83;

  pth_comp_delay #(.WIDTH(16), .DEPTH(5)) u_ah_dly (.clk(clk), .din(adc_hum), .dout(ah5));

  assign s14_s_w = asr32(s11_xx, 15);
  assign hx_w    = s13_xx - asr32(s13_t, 4);

  always_ff @(posedge clk) begin
    s5_h5x <= h5 * s4_x;
    s5_x6  <= s4_x * h6;
    s5_x3  <= s4_x * h3;
    s6_a   <= asr32(({16'd0, ah5} << 14) - (h4 << 20) - s5_h5x + 32'd16384, 15);
    s6_f1  <= asr32(s5_x6, 10);
    s6_f2  <= asr32(s5_x3, 11) + 32'd32768;
    s7_bm  <= s6_f1 * s6_f2;
    s7_a   <= s6_a;
    s8_b1  <= asr32(s7_bm, 10) + HUM_BIAS;
    s8_a   <= s7_a;
    s9_b2  <= s8_b1 * h2;
    s9_a   <= s8_a;
    s10_b  <= asr32(s9_b2 + 32'd8192, 14);
    s10_a  <= s9_a;
    s11_xx <= s10_a * s10_b;
    s12_ss <= s14_s_w * s14_s_w;
    s12_xx <= s11_xx;
    s13_t  <= asr32(s12_ss, 7) * h1;
    s13_xx <= s12_xx;
    if (hx_w[31]) begin
      s14_hum <= '0;
    end else if (hx_w > HUM_LIMIT) begin
      s14_hum <= HUM_LIMIT[28:12];
    end else begin
      s14_hum <= hx_w[28:12];
    end
  end

  pth_comp_delay #(.WIDTH(17), .DEPTH(69)) u_hum_dly (.clk(clk), .din(s14_hum), .dout(hum83));
  pth_comp_delay #(.WIDTH(32), .DEPTH(80)) u_tf_dly (.clk(clk), .din(s3_tf), .dout(tf83));
  pth_comp_delay #(.WIDTH(32), .DEPTH(79)) u_tc_dly (.clk(clk), .din(s4_temp), .dout(temp83));

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    temp_centideg <= $signed(temp83);
    fine_temp     <= $signed(tf83);
    hum_q22_10    <= hum83;
    calib_error   <= err83;
    if (err83 || r_w[63]) begin
      press_q24_8 <= '0;
    end else if (r_w[63:32] != 32'd0) begin
      press_q24_8 <= '1;
    end else begin
      press_q24_8 <= r_w[31:0];
    end
  end

`ifndef ASSERT_OFF
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && calib_error) |-> (press_q24_8 == 32'd0))
    else $error("pressure not zero on calibration error");

  a_hum_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (hum_q22_10 <= 17'd102400))
    else $error("humidity above full scale");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without matching input word");
`endif

endmodule

// ----- tb/pth_comp_checker.sv -----
// Checker for pth_sensor_compensation_top: predicts each result from the calibration copy.
// Depends on pth_comp_pkg for register indexes and constants.
`timescale 1ns / 1ps

module pth_comp_checker
  import pth_comp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [19:0]        adc_temp,
  input  logic [19:0]        adc_press,
  input  logic [15:0]        adc_hum,
  input  logic               done,
  input  logic signed [31:0] temp_centideg,
  input  logic signed [31:0] fine_temp,
  input  logic [31:0]        press_q24_8,
  input  logic [16:0]        hum_q22_10,
  input  logic               calib_error,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_addr,
  input  logic [63:0]        cfg_data,
  output int                 n_fail,
  output int                 n_pending
);

  typedef struct packed {
    logic [31:0] temp;
    logic [31:0] fine;
    logic [31:0] press;
    logic [16:0] hum;
    logic        err;
  } reading_t;

  logic [63:0] cal_t, cal_pl, cal_ph, cal_m, cal_h;
  reading_t    expected_q[$];

  function automatic logic [31:0] sra32(input logic [31:0] v, input int n);
    return $signed(v) >>> n;
  endfunction

  function automatic logic [63:0] sra64(input logic [63:0] v, input int n);
    return $signed(v) >>> n;
  endfunction

  // signed divide, truncating toward zero
  function automatic logic [63:0] sdiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] an, ad, qq;
    an = num[63] ? -num : num;
    ad = den[63] ? -den : den;
    qq = an / ad;
    return (num[63] ^ den[63]) ? -qq : qq;
  endfunction

  function automatic reading_t compensate(input logic [19:0] raw_t, input logic [19:0] raw_p,
                                          input logic [15:0] raw_h);
    logic [31:0] at, ah, t1, t2, t3, v1, dd, v2, tf, x, a, b, s;
    logic [31:0] h1, h2, h3, h4, h5, h6;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, w1, w2, p, q, r;
    reading_t    res;
    at = 32'(raw_t);
    ah = 32'(raw_h);
    t1 = 32'(cal_t[15:0]);
    t2 = 32'($signed(cal_t[31:16]));
    t3 = 32'($signed(cal_t[47:32]));
    p1 = 64'(cal_pl[15:0]);
    p2 = 64'($signed(cal_pl[31:16]));
    p3 = 64'($signed(cal_pl[47:32]));
    p4 = 64'($signed(cal_pl[63:48]));
    p5 = 64'($signed(cal_ph[15:0]));
    p6 = 64'($signed(cal_ph[31:16]));
    p7 = 64'($signed(cal_ph[47:32]));
    p8 = 64'($signed(cal_ph[63:48]));
    p9 = 64'($signed(cal_m[15:0]));
    h1 = 32'(cal_m[23:16]);
    h2 = 32'($signed(cal_m[39:24]));
    h3 = 32'(cal_m[47:40]);
    h4 = 32'($signed(cal_h[11:0]));
    h5 = 32'($signed(cal_h[23:12]));
    h6 = 32'($signed(cal_h[31:24]));

    v1 = sra32(((at >> 3) - (t1 << 1)) * t2, 11);
    dd = (at >> 4) - t1;
    v2 = sra32(sra32(dd * dd, 12) * t3, 14);
    tf = v1 + v2;
    res.fine = tf;
    res.temp = sra32(tf * 32'd5 + 32'd128, 8);

    res.press = '0;
    res.err   = 1'b0;
    w1 = {{32{tf[31]}}, tf} - PW_OFFSET;
    w2 = w1 * w1 * p6;
    w2 = w2 + ((w1 * p5) << 17);
    w2 = w2 + (p4 << 35);
    w1 = sra64(w1 * w1 * p3, 8) + ((w1 * p2) << 12);
    w1 = sra64(((64'd1 << 47) + w1) * p1, 33);
    if (w1 == 64'd0) begin
      res.err = 1'b1;
    end else begin
      p  = PRESS_BASE - {44'd0, raw_p};
      p  = sdiv64(((p << 31) - w2) * PRESS_MUL, w1);
      q  = sra64(p, 13);
      w1 = sra64(p9 * q * q, 25);
      w2 = sra64(p8 * p, 19);
      r  = sra64(p + w1 + w2, 8) + (p7 << 4);
      if (r[63]) res.press = '0;
      else if (r[63:32] != 0) res.press = 32'hFFFF_FFFF;
      else res.press = r[31:0];
    end

    x = tf - HX_OFFSET;
    a = (ah << 14) - (h4 << 20) - (h5 * x);
    a = sra32(a + 32'd16384, 15);
    b = sra32(x * h6, 10) * (sra32(x * h3, 11) + 32'd32768);
    b = sra32(b, 10) + HUM_BIAS;
    b = sra32(b * h2 + 32'd8192, 14);
    x = a * b;
    s = sra32(x, 15);
    x = x - sra32(sra32(s * s, 7) * h1, 4);
    if (x[31]) x = '0;
    else if (x > HUM_LIMIT) x = HUM_LIMIT;
    res.hum = x[28:12];
    return res;
  endfunction

  assign n_pending = expected_q.size();

  always @(posedge clk) begin
    reading_t got, want;
    if (rst) begin
      cal_t  <= '0;
      cal_pl <= '0;
      cal_ph <= '0;
      cal_m  <= '0;
      cal_h  <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_TEMP:       cal_t  <= cfg_data & 64'h0000_FFFF_FFFF_FFFF;
          CFG_PRESS_LOW:  cal_pl <= cfg_data;
          CFG_PRESS_HIGH: cal_ph <= cfg_data;
          CFG_MIXED:      cal_m  <= cfg_data & 64'h0000_FFFF_FFFF_FFFF;
          CFG_HUM:        cal_h  <= cfg_data & 64'h0000_0000_FFFF_FFFF;
          default: ;
        endcase
      end
      if (start && !busy) expected_q.push_back(compensate(adc_temp, adc_press, adc_hum));
      if (done) begin
        got = '{temp_centideg, fine_temp, press_q24_8, hum_q22_10, calib_error};
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result word %h", $time, got);
          n_fail++;
        end else begin
          want = expected_q.pop_front();
          if (got.temp !== want.temp) begin
            $display("%0t: temp_centideg exp %0d got %0d", $time, $signed(want.temp),
                     $signed(got.temp));
            n_fail++;
          end
          if (got.fine !== want.fine) begin
            $display("%0t: fine_temp exp %0d got %0d", $time, $signed(want.fine),
                     $signed(got.fine));
            n_fail++;
          end
          if (got.press !== want.press) begin
            $display("%0t: press_q24_8 exp %h got %h", $time, want.press, got.press);
            n_fail++;
          end
          if (got.hum !== want.hum) begin
            $display("%0t: hum_q22_10 exp %0d got %0d", $time, want.hum, got.hum);
            n_fail++;
          end
          if (got.err !== want.err) begin
            $display("%0t: calib_error exp %b got %b", $time, want.err, got.err);
            n_fail++;
          end
        end
      end
    end
  end

endmodule

// ----- tb/testbench.sv -----
// Top of the compensation testbench: clock, reset, calibration writes and measurement words.
// Depends on pth_comp_pkg, pth_sensor_compensation_top and pth_comp_checker.
`timescale 1ns / 1ps

module testbench;
  import pth_comp_pkg::*;

  localparam int MAX_CYCLES = 400000;
  // extra wait after the last result comes out; leave margin
  localparam int DRAIN = 120;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [19:0]        adc_temp = '0;
  logic [19:0]        adc_press = '0;
  logic [15:0]        adc_hum = '0;
  logic               done;
  logic signed [31:0] temp_centideg, fine_temp;
  logic [31:0]        press_q24_8;
  logic [16:0]        hum_q22_10;
  logic               calib_error;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_addr = '0;
  logic [63:0]        cfg_data = '0;
  int                 n_fail, n_pending;
  int                 cycles = 0;
  int                 idle_pct = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  pth_sensor_compensation_top dut (.*);

  pth_comp_checker chk (.*);

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // one register write, lasting one cycle
  task automatic write_cal(input logic [2:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  // typical factory calibration, with optional random jitter on every field
  task automatic load_typical(input bit jitter);
    logic [63:0] r0, r1, r2, r3, r4;
    r0 = {16'd0, 16'hFC18, 16'd26435, 16'd27504};                     // T3=-1000
    r1 = {16'd2855, 16'd3024, 16'hD643, 16'd36477};                   // P2=-10685
    r2 = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};                    // P8=-14600, P6=-7
    r3 = {16'd0, 8'd0, 16'd362, 8'd75, 16'd6000};
    r4 = {32'd0, 8'd30, 12'd0, 12'd324};
    if (jitter) begin
      r0 ^= {$urandom, $urandom} & 64'h0000_003F_00FF_03FF;
      r1 ^= {$urandom, $urandom} & 64'h00FF_00FF_00FF_00FF;
      r2 ^= {$urandom, $urandom} & 64'h003F_00FF_000F_003F;
      r3 ^= {$urandom, $urandom} & 64'h0000_FF03_FFFF_03FF;
      r4 ^= {$urandom, $urandom} & 64'h0000_0000_0F0F_F03F;
    end
    write_cal(CFG_TEMP, r0);
    write_cal(CFG_PRESS_LOW, r1);
    write_cal(CFG_PRESS_HIGH, r2);
    write_cal(CFG_MIXED, r3);
    write_cal(CFG_HUM, r4);
  endtask

  task automatic load_all(input logic [63:0] val);
    write_cal(CFG_TEMP, val);
    write_cal(CFG_PRESS_LOW, val);
    write_cal(CFG_PRESS_HIGH, val);
    write_cal(CFG_MIXED, val);
    write_cal(CFG_HUM, val);
  endtask

  // one measurement word; start stays high across back-to-back words
  task automatic send_word(input logic [19:0] t, input logic [19:0] p, input logic [15:0] h);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start     <= 1'b1;
    adc_temp  <= t;
    adc_press <= p;
    adc_hum   <= h;
    do @(posedge clk); while (busy);
  endtask

  // let every word in flight come out before touching calibration
  task automatic drain;
    @(negedge clk);
    start <= 1'b0;
    while (n_pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic send_random(input int count);
    logic [19:0] t, p;
    logic [15:0] h;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(3) != 0) begin
        // plausible raw levels around room conditions
        t = 20'd400000 + 20'($urandom_range(300000));
        p = 20'd250000 + 20'($urandom_range(300000));
        h = 16'd20000 + 16'($urandom_range(30000));
      end else begin
        t = 20'($urandom);
        p = 20'($urandom);
        h = 16'($urandom);
      end
      send_word(t, p, h);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset calibration: P1 is zero, so the divisor is zero and the error flag shows
    send_word('0, '0, '0);
    send_word('1, '1, '1);
    drain();

    // directed: field extremes under a typical calibration
    load_typical(1'b0);
    write_cal(3'd5, '1);                      // out-of-range indexes must not land
    write_cal(3'd7, 64'h1234_5678_9ABC_DEF0);
    send_word('0, '0, '0);
    send_word('1, '1, '1);
    send_word('1, '0, '0);
    send_word('0, '1, '0);
    send_word('0, '0, '1);
    send_word(20'd519888, 20'd415148, 16'd26000);
    send_word(20'd519888, 20'd0, 16'd65535);  // high pressure, saturating humidity
    send_word(20'd519888, 20'd1048575, 16'd0);
    send_word(20'h80000, 20'h80000, 16'h8000);
    send_word(20'h7FFFF, 20'h7FFFF, 16'h7FFF);
    drain();

    // extreme calibrations: all ones, then alternating bits
    load_all('1);
    send_word('0, '0, '0);
    send_word('1, '1, '1);
    send_word(20'h55555, 20'hAAAAA, 16'h5A5A);
    drain();
    load_all(64'h5555_5555_5555_5555);
    send_word('0, '1, '1);
    send_word('1, '0, '0);
    drain();
    // most negative signed fields
    load_all(64'h8000_8000_8000_8000);
    send_word(20'h12345, 20'hFEDCB, 16'h1234);
    drain();

    // random phases, idling varied per phase
    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: idle_pct = 0;
        1: idle_pct = 87;
        2: idle_pct = 0;
        default: idle_pct = 17;
      endcase
      if (ph == 5) begin
        load_all({$urandom, $urandom});
        send_random(40);
      end else if (ph == 9) begin
        load_all('0);
        send_random(20);
      end else begin
        load_typical(ph != 0);
        send_random(85);
      end
      drain();
    end

    if (n_fail == 0 && n_pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/pth_comp_pkg.sv
rtl/pth_comp_delay.sv
rtl/pth_comp_mul64.sv
rtl/pth_comp_div64.sv
rtl/pth_sensor_compensation_top.sv
tb/pth_comp_checker.sv
tb/testbench.sv
